[src/mail_record_field_parser_macros.svh]
`ifndef MAIL_RECORD_FIELD_PARSER_MACROS_SVH
`define MAIL_RECORD_FIELD_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define MRFP_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("mail record field parser check failed");

`define MRFP_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("mail record field parser check failed");

`else

`define MRFP_ASSERT_NOW(label, pre, post)

`define MRFP_ASSERT_NEXT(label, pre, post)

`endif

`endif

[src/mrfp_pkg.sv]
`default_nettype none

package mrfp_pkg;

   typedef enum logic [4:0] {
      KIND_LENGTH           = 5'd0,
      KIND_FLAGS            = 5'd1,
      KIND_TIMESTAMP        = 5'd2,
      KIND_PARENT_COUNT     = 5'd3,
      KIND_PARENT_ID        = 5'd4,
      KIND_ENCODING         = 5'd5,
      KIND_ATTACH_COUNT     = 5'd6,
      KIND_ENCRYPTION       = 5'd7,
      KIND_COMPRESSION      = 5'd8,
      KIND_HEADER_COUNT     = 5'd9,
      KIND_HEADER_ID        = 5'd10,
      KIND_HEADER_LEN       = 5'd11,
      KIND_HEADER_BYTE      = 5'd12,
      KIND_BODY_LEN         = 5'd13,
      KIND_BODY_BYTE        = 5'd14,
      KIND_ATTACH_FLAGS     = 5'd15,
      KIND_MIME             = 5'd16,
      KIND_NAME_LEN         = 5'd17,
      KIND_NAME_BYTE        = 5'd18,
      KIND_ATTACH_BODY_LEN  = 5'd19,
      KIND_ATTACH_BODY_BYTE = 5'd20,
      KIND_MSGID            = 5'd21
   } kind_type;

   localparam int FLAG_ATTACH      = 3;
   localparam int FLAG_PARENTS     = 4;
   localparam int FLAG_COMPRESSION = 5;
   localparam int FLAG_ENCODING    = 6;
   localparam int FLAG_ENCRYPTION  = 7;
   localparam int FLAG_TIMESTAMP   = 9;

   localparam int FLAGS_W = 10;
   localparam int RSP_DATA_W = 72;

   function automatic logic [3:0] field_size(kind_type kind);
      logic [3:0] size;
      case (kind)
         KIND_LENGTH, KIND_PARENT_ID, KIND_HEADER_ID, KIND_BODY_LEN,
         KIND_ATTACH_BODY_LEN, KIND_MSGID: size = 4'd4;
         KIND_FLAGS, KIND_PARENT_COUNT, KIND_ENCODING, KIND_ATTACH_COUNT,
         KIND_HEADER_LEN, KIND_MIME, KIND_NAME_LEN: size = 4'd2;
         KIND_TIMESTAMP: size = 4'd8;
         default: size = 4'd1;
      endcase
      return size;
   endfunction

   // Walk past absent optional fields and empty loops.
   function automatic kind_type skip_fields(kind_type start, logic [FLAGS_W-1:0] flags,
                                            logic items_zero, logic attach_zero,
                                            logic payload_zero);
      kind_type p;
      logic     moved;
      p = start;
      moved = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (moved) begin
            moved = 1'b0;
            case (p)
               KIND_TIMESTAMP: if (!flags[FLAG_TIMESTAMP]) begin
                  p = KIND_PARENT_COUNT; moved = 1'b1;
               end
               KIND_PARENT_COUNT: if (!flags[FLAG_PARENTS]) begin
                  p = KIND_ENCODING; moved = 1'b1;
               end
               KIND_PARENT_ID: if (items_zero) begin
                  p = KIND_ENCODING; moved = 1'b1;
               end
               KIND_ENCODING: if (!flags[FLAG_ENCODING]) begin
                  p = KIND_ATTACH_COUNT; moved = 1'b1;
               end
               KIND_ATTACH_COUNT: if (!flags[FLAG_ATTACH]) begin
                  p = KIND_ENCRYPTION; moved = 1'b1;
               end
               KIND_ENCRYPTION: if (!flags[FLAG_ENCRYPTION]) begin
                  p = KIND_COMPRESSION; moved = 1'b1;
               end
               KIND_COMPRESSION: if (!flags[FLAG_COMPRESSION]) begin
                  p = KIND_HEADER_COUNT; moved = 1'b1;
               end
               KIND_HEADER_ID: if (items_zero) begin
                  p = KIND_BODY_LEN; moved = 1'b1;
               end
               KIND_HEADER_BYTE: if (payload_zero) begin
                  p = KIND_HEADER_ID; moved = 1'b1;
               end
               KIND_BODY_BYTE: if (payload_zero) begin
                  p = KIND_ATTACH_FLAGS; moved = 1'b1;
               end
               KIND_ATTACH_FLAGS: if (!flags[FLAG_ATTACH] || attach_zero) begin
                  p = KIND_MSGID; moved = 1'b1;
               end
               KIND_NAME_BYTE: if (payload_zero) begin
                  p = KIND_ATTACH_BODY_LEN; moved = 1'b1;
               end
               KIND_ATTACH_BODY_BYTE: if (payload_zero) begin
                  p = KIND_ATTACH_FLAGS; moved = 1'b1;
               end
               default: moved = 1'b0;
            endcase
         end
      end
      return p;
   endfunction

endpackage

`default_nettype wire

[src/mail_record_field_parser.sv]
// Mail archive record field parser.
// req channel: one record byte per request in req_tdata; req_tuser set marks the
// byte as the first byte of a new record and clears all parser state first.
// rsp channel: one request per completed field, carrying the field kind and its
// little-endian value (payload bytes carry the byte itself); rsp_tlast is set
// on the message id that ends a record. Bytes that only extend a field, or that
// fall in skipped parts, give no response.
// Path: an accepted byte passes the input register, then the response register.
// Throughput: one byte per cycle; the input register and the response
// register each advance every cycle while the response side takes data.
// Reset: synchronous, active high; the parser then expects the length field of
// a new record and both registers are empty.
// Stall: while rsp_tready is low a held response blocks the input register,
// which then holds one more byte before req_tready drops.
`default_nettype none
`include "mail_record_field_parser_macros.svh"

module mail_record_field_parser
   import mrfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tuser,   // [0] record_start
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [4:0] field_kind, [68:5] field_value
   output logic                       rsp_tlast    // record_done
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_start_ff;

   kind_type             phase_ff, phase_in;
   logic [2:0]           bif_ff, bif_in;
   logic [63:0]          acc_ff, acc_in;
   logic [FLAGS_W-1:0]   flags_ff, flags_in;
   logic [15:0]          items_ff, items_in;
   logic [15:0]          attach_ff, attach_in;
   logic [31:0]          payload_ff, payload_in;

   logic                 out_valid_ff;
   kind_type             out_kind_ff;
   logic [63:0]          out_value_ff;
   logic                 out_done_ff;

   logic                 advance;
   logic                 clear;
   kind_type             cur_phase;
   logic [2:0]           cur_bif;
   logic [63:0]          cur_acc;
   logic [FLAGS_W-1:0]   cur_flags;
   logic [15:0]          cur_items;
   logic [15:0]          cur_attach;
   logic [31:0]          cur_payload;
   logic [63:0]          acc_new;
   logic [63:0]          value;
   logic                 partial;
   kind_type             target;
   logic                 in_payload_phase;
   logic                 in_count_phase;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign clear       = in_start_ff || (phase_ff > KIND_MSGID);
   assign cur_phase   = clear ? KIND_LENGTH : phase_ff;
   assign cur_bif     = clear ? 3'd0 : bif_ff;
   assign cur_acc     = clear ? 64'd0 : acc_ff;
   assign cur_flags   = clear ? '0 : flags_ff;
   assign cur_items   = clear ? 16'd0 : items_ff;
   assign cur_attach  = clear ? 16'd0 : attach_ff;
   assign cur_payload = clear ? 32'd0 : payload_ff;

   assign acc_new = cur_acc | (64'(in_byte_ff) << {cur_bif, 3'b000});
   assign partial = ({1'b0, cur_bif} + 4'd1) < field_size(cur_phase);

   always_comb begin
      value      = acc_new;
      flags_in   = cur_flags;
      items_in   = cur_items;
      attach_in  = cur_attach;
      payload_in = cur_payload;
      target     = cur_phase;
      case (cur_phase)
         KIND_LENGTH: target = KIND_FLAGS;
         KIND_FLAGS: begin
            value     = {54'd0, acc_new[FLAGS_W-1:0]};
            flags_in  = acc_new[FLAGS_W-1:0];
            items_in  = 16'd0;
            attach_in = 16'd0;
            target    = KIND_TIMESTAMP;
         end
         KIND_PARENT_COUNT: begin
            items_in = acc_new[15:0];
            target   = KIND_PARENT_ID;
         end
         KIND_PARENT_ID: begin
            items_in = cur_items - 16'd1;
            target   = KIND_PARENT_ID;
         end
         KIND_ATTACH_COUNT: begin
            attach_in = acc_new[15:0];
            target    = KIND_ENCRYPTION;
         end
         KIND_HEADER_COUNT: begin
            items_in = {8'd0, acc_new[7:0]};
            target   = KIND_HEADER_ID;
         end
         KIND_HEADER_ID: begin
            items_in = cur_items - 16'd1;
            target   = KIND_HEADER_LEN;
         end
         KIND_HEADER_LEN: begin
            payload_in = {16'd0, acc_new[15:0]};
            target     = KIND_HEADER_BYTE;
         end
         KIND_BODY_LEN: begin
            payload_in = acc_new[31:0];
            target     = KIND_BODY_BYTE;
         end
         KIND_ATTACH_FLAGS: begin
            value     = {60'd0, acc_new[3:0]};
            attach_in = cur_attach - 16'd1;
            target    = KIND_MIME;
         end
         KIND_NAME_LEN: begin
            payload_in = {16'd0, acc_new[15:0]};
            target     = KIND_NAME_BYTE;
         end
         KIND_ATTACH_BODY_LEN: begin
            payload_in = acc_new[31:0];
            target     = KIND_ATTACH_BODY_BYTE;
         end
         KIND_HEADER_BYTE, KIND_BODY_BYTE, KIND_NAME_BYTE, KIND_ATTACH_BODY_BYTE: begin
            payload_in = cur_payload - 32'd1;
            target     = cur_phase;
         end
         KIND_MSGID: target = KIND_LENGTH;
         default: target = kind_type'(5'(cur_phase) + 5'd1);
      endcase
   end

   always_comb begin
      if (partial) begin
         phase_in = cur_phase;
         bif_in   = cur_bif + 3'd1;
         acc_in   = acc_new;
      end else begin
         phase_in = skip_fields(target, flags_in, items_in == 16'd0,
                                attach_in == 16'd0, payload_in == 32'd0);
         bif_in   = 3'd0;
         acc_in   = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= KIND_LENGTH;
         bif_ff       <= 3'd0;
         acc_ff       <= 64'd0;
         flags_ff     <= '0;
         items_ff     <= 16'd0;
         attach_ff    <= 16'd0;
         payload_ff   <= 32'd0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_tdata;
            in_start_ff <= req_tuser;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff   <= phase_in;
            bif_ff     <= bif_in;
            acc_ff     <= acc_in;
            flags_ff   <= partial ? cur_flags : flags_in;
            items_ff   <= partial ? cur_items : items_in;
            attach_ff  <= partial ? cur_attach : attach_in;
            payload_ff <= partial ? cur_payload : payload_in;
         end
         if (advance && !partial) begin
            out_valid_ff <= 1'b1;
            out_kind_ff  <= cur_phase;
            out_value_ff <= value;
            out_done_ff  <= cur_phase == KIND_MSGID;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_value_ff, 5'(out_kind_ff)};
   assign rsp_tlast  = out_done_ff;

   assign in_payload_phase = phase_ff inside {KIND_HEADER_BYTE, KIND_BODY_BYTE, KIND_NAME_BYTE,
                                              KIND_ATTACH_BODY_BYTE};
   assign in_count_phase   = phase_ff inside {KIND_PARENT_ID, KIND_HEADER_ID};

   `MRFP_ASSERT_NOW(a_done_on_msgid, rsp_tvalid && rsp_tlast, rsp_tdata[4:0] == 5'(KIND_MSGID))
   `MRFP_ASSERT_NOW(a_payload_nonzero, in_payload_phase, payload_ff != 32'd0)
   `MRFP_ASSERT_NOW(a_items_nonzero, in_count_phase, items_ff != 16'd0)
   `MRFP_ASSERT_NEXT(a_field_restart, advance && !partial, bif_ff == 3'd0 && acc_ff == 64'd0)

endmodule

`default_nettype wire

[tb/mail_record_field_parser_checker.sv]
`default_nettype none

module mail_record_field_parser_checker
   import mrfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tuser,   // [0] record_start
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,   // [4:0] field_kind, [68:5] field_value
   input  wire logic                  rsp_tlast,   // record_done
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] value;
      logic        done;
   } field_result_type;

   field_result_type expected_fields[$];

   kind_type    cur_kind;
   logic [2:0]  byte_idx;
   logic [63:0] acc;
   logic [9:0]  rec_flags;
   logic [15:0] items_cnt;
   logic [15:0] attach_cnt;
   logic [31:0] payload_cnt;

   function automatic int bytes_of(kind_type k);
      case (k)
         KIND_TIMESTAMP: return 8;
         KIND_LENGTH, KIND_PARENT_ID, KIND_HEADER_ID, KIND_BODY_LEN,
         KIND_ATTACH_BODY_LEN, KIND_MSGID: return 4;
         KIND_FLAGS, KIND_PARENT_COUNT, KIND_ENCODING, KIND_ATTACH_COUNT,
         KIND_HEADER_LEN, KIND_MIME, KIND_NAME_LEN: return 2;
         default: return 1;
      endcase
   endfunction

   // Advance past absent optional fields and empty loops.
   function automatic kind_type next_present(kind_type start_kind);
      kind_type k;
      logic     moved;
      k = start_kind;
      moved = 1'b1;
      while (moved) begin
         moved = 1'b1;
         case (k)
            KIND_TIMESTAMP:    if (!rec_flags[FLAG_TIMESTAMP]) k = KIND_PARENT_COUNT; else moved = 1'b0;
            KIND_PARENT_COUNT: if (!rec_flags[FLAG_PARENTS]) k = KIND_ENCODING; else moved = 1'b0;
            KIND_PARENT_ID:    if (items_cnt == 0) k = KIND_ENCODING; else moved = 1'b0;
            KIND_ENCODING:     if (!rec_flags[FLAG_ENCODING]) k = KIND_ATTACH_COUNT; else moved = 1'b0;
            KIND_ATTACH_COUNT: if (!rec_flags[FLAG_ATTACH]) k = KIND_ENCRYPTION; else moved = 1'b0;
            KIND_ENCRYPTION:   if (!rec_flags[FLAG_ENCRYPTION]) k = KIND_COMPRESSION; else moved = 1'b0;
            KIND_COMPRESSION:  if (!rec_flags[FLAG_COMPRESSION]) k = KIND_HEADER_COUNT; else moved = 1'b0;
            KIND_HEADER_ID:    if (items_cnt == 0) k = KIND_BODY_LEN; else moved = 1'b0;
            KIND_HEADER_BYTE:  if (payload_cnt == 0) k = KIND_HEADER_ID; else moved = 1'b0;
            KIND_BODY_BYTE:    if (payload_cnt == 0) k = KIND_ATTACH_FLAGS; else moved = 1'b0;
            KIND_ATTACH_FLAGS:
               if (!rec_flags[FLAG_ATTACH] || attach_cnt == 0) k = KIND_MSGID; else moved = 1'b0;
            KIND_NAME_BYTE:    if (payload_cnt == 0) k = KIND_ATTACH_BODY_LEN; else moved = 1'b0;
            KIND_ATTACH_BODY_BYTE: if (payload_cnt == 0) k = KIND_ATTACH_FLAGS; else moved = 1'b0;
            default: moved = 1'b0;
         endcase
      end
      return k;
   endfunction

   task automatic move_to(kind_type k);
      cur_kind = next_present(k);
      byte_idx = '0;
      acc = '0;
   endtask

   task automatic clear_parser();
      cur_kind = KIND_LENGTH;
      byte_idx = '0;
      acc = '0;
      rec_flags = '0;
      items_cnt = '0;
      attach_cnt = '0;
      payload_cnt = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic start);
      kind_type         k;
      logic [63:0]      v;
      field_result_type res;
      if (start || cur_kind > KIND_MSGID) clear_parser();
      k = cur_kind;
      acc = acc | (64'(b) << (8 * byte_idx));
      if (int'(byte_idx) + 1 < bytes_of(k)) begin
         byte_idx = byte_idx + 3'd1;
         return;
      end
      v = acc;
      case (k)
         KIND_LENGTH: move_to(KIND_FLAGS);
         KIND_FLAGS: begin
            v = v & 64'h3FF;
            rec_flags = v[9:0];
            items_cnt = '0;
            attach_cnt = '0;
            move_to(KIND_TIMESTAMP);
         end
         KIND_PARENT_COUNT: begin
            items_cnt = v[15:0];
            move_to(KIND_PARENT_ID);
         end
         KIND_PARENT_ID: begin
            items_cnt = items_cnt - 16'd1;
            move_to(KIND_PARENT_ID);
         end
         KIND_ATTACH_COUNT: begin
            attach_cnt = v[15:0];
            move_to(KIND_ENCRYPTION);
         end
         KIND_HEADER_COUNT: begin
            items_cnt = {8'd0, v[7:0]};
            move_to(KIND_HEADER_ID);
         end
         KIND_HEADER_ID: begin
            items_cnt = items_cnt - 16'd1;
            move_to(KIND_HEADER_LEN);
         end
         KIND_HEADER_LEN: begin
            payload_cnt = {16'd0, v[15:0]};
            move_to(KIND_HEADER_BYTE);
         end
         KIND_BODY_LEN: begin
            payload_cnt = v[31:0];
            move_to(KIND_BODY_BYTE);
         end
         KIND_ATTACH_FLAGS: begin
            v = v & 64'hF;
            attach_cnt = attach_cnt - 16'd1;
            move_to(KIND_MIME);
         end
         KIND_NAME_LEN: begin
            payload_cnt = {16'd0, v[15:0]};
            move_to(KIND_NAME_BYTE);
         end
         KIND_ATTACH_BODY_LEN: begin
            payload_cnt = v[31:0];
            move_to(KIND_ATTACH_BODY_BYTE);
         end
         KIND_HEADER_BYTE, KIND_BODY_BYTE, KIND_NAME_BYTE, KIND_ATTACH_BODY_BYTE: begin
            payload_cnt = payload_cnt - 32'd1;
            move_to(k);
         end
         KIND_MSGID: move_to(KIND_LENGTH);
         default: move_to(kind_type'(k + 5'd1));
      endcase
      res.kind = k;
      res.value = v;
      res.done = (k == KIND_MSGID);
      expected_fields.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      field_result_type want;
      if (reset) begin
         clear_parser();
         expected_fields.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_fields.size() == 0) begin
               $error("unexpected response: kind %0d value 0x%0h",
                      rsp_tdata[4:0], rsp_tdata[68:5]);
               fail_count++;
            end else begin
               want = expected_fields.pop_front();
               check_field("field_kind", 64'(want.kind), 64'(rsp_tdata[4:0]));
               check_field("field_value", want.value, rsp_tdata[68:5]);
               check_field("record_done", 64'(want.done), 64'(rsp_tlast));
               check_field("padding", 64'd0, 64'(rsp_tdata[RSP_DATA_W-1:69]));
            end
         end
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tuser);
      end
      pending = expected_fields.size();
   end

endmodule

`default_nettype wire

[tb/mail_record_field_parser_tb.sv]
`default_nettype none

module mail_record_field_parser_tb
   import mrfp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int BYTES_PER_PHASE = 570;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'd0;   // [7:0] data_byte
   logic                  req_tuser = 1'b0;   // [0] record_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [4:0] field_kind, [68:5] field_value
   logic                  rsp_tlast;          // record_done

   int fail_count;
   int pending;
   int send_idle = 0;
   int recv_idle = 0;
   int sent_count = 0;
   int quiet_cycles = 0;

   logic [7:0] rec_bytes[$];

   mail_record_field_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   mail_record_field_parser_checker field_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int pick_count(input int max_n);
      if ($urandom_range(29) == 0) return $urandom_range(max_n * 20);
      return $urandom_range(max_n);
   endfunction

   task automatic put_le(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) rec_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic build_record(input logic [15:0] fw);
      int n_items;
      int n_attach;
      int len;
      rec_bytes.delete();
      put_le(64'($urandom), 4);
      put_le(64'(fw), 2);
      if (fw[FLAG_TIMESTAMP]) put_le({$urandom, $urandom}, 8);
      if (fw[FLAG_PARENTS]) begin
         n_items = pick_count(3);
         put_le(64'(n_items), 2);
         repeat (n_items) put_le(64'($urandom), 4);
      end
      if (fw[FLAG_ENCODING]) put_le(64'($urandom), 2);
      n_attach = 0;
      if (fw[FLAG_ATTACH]) begin
         n_attach = pick_count(2);
         put_le(64'(n_attach), 2);
      end
      if (fw[FLAG_ENCRYPTION]) put_le(64'($urandom), 1);
      if (fw[FLAG_COMPRESSION]) put_le(64'($urandom), 1);
      n_items = pick_count(3);
      put_le(64'(n_items), 1);
      repeat (n_items) begin
         put_le(64'($urandom), 4);
         len = pick_count(5);
         put_le(64'(len), 2);
         repeat (len) put_le(64'($urandom), 1);
      end
      len = pick_count(8);
      put_le(64'(len), 4);
      repeat (len) put_le(64'($urandom), 1);
      repeat (n_attach) begin
         put_le(64'($urandom), 1);
         put_le(64'($urandom), 2);
         len = pick_count(4);
         put_le(64'(len), 2);
         repeat (len) put_le(64'($urandom), 1);
         len = pick_count(6);
         put_le(64'(len), 4);
         repeat (len) put_le(64'($urandom), 1);
      end
      put_le(64'($urandom), 4);
   endtask

   // Entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic s);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= s;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_record(input logic s0, input int cut);
      for (int i = 0; i < cut; i++) send_byte(rec_bytes[i], (i == 0) ? s0 : 1'b0);
   endtask

   initial begin
      int   target;
      int   n;
      int   choice;
      logic broken;
      broken = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle = 10; recv_idle = 55; end
            1: begin send_idle = 55; recv_idle = 10; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         if (ph == 0) begin
            // every optional field present, reserved flag bits set, all counts zero
            rec_bytes.delete();
            put_le(64'h0000_0000_FFFF_FFFF, 4);
            put_le(64'h0000_0000_0000_FFFF, 2);
            put_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
            put_le(64'h0, 2);
            put_le(64'h0000_0000_0000_FFFF, 2);
            put_le(64'h0, 2);
            put_le(64'h0000_0000_0000_00FF, 1);
            put_le(64'h0000_0000_0000_00FF, 1);
            put_le(64'h0, 1);
            put_le(64'h0, 4);
            put_le(64'h0000_0000_FFFF_FFFF, 4);
            send_record(1'b1, rec_bytes.size());
            // no options, zero lengths, follows the previous message id directly
            rec_bytes.delete();
            put_le(64'h0, 4);
            put_le(64'h0, 2);
            put_le(64'h0, 1);
            put_le(64'h0, 4);
            put_le(64'h0, 4);
            send_record(1'b0, rec_bytes.size());
            // partial length field, then resynchronise
            repeat (3) send_byte(8'hA5, 1'b0);
            build_record(16'h03F8);
            send_record(1'b1, rec_bytes.size());
         end
         target = sent_count + BYTES_PER_PHASE;
         while (sent_count < target) begin
            choice = $urandom_range(9);
            if (choice == 0) begin
               n = $urandom_range(1, 12);
               repeat (n) send_byte(8'($urandom), ($urandom_range(3) == 0));
               broken = 1'b1;
            end else if (choice == 1) begin
               build_record(16'($urandom));
               send_record(broken | 1'($urandom_range(1)),
                           $urandom_range(1, rec_bytes.size() - 1));
               broken = 1'b1;
            end else begin
               build_record(16'($urandom));
               send_record(broken | 1'($urandom_range(1)), rec_bytes.size());
               broken = 1'b0;
            end
         end
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/mrfp_pkg.sv
src/mail_record_field_parser.sv
tb/mail_record_field_parser_checker.sv
tb/mail_record_field_parser_tb.sv
